/* rtl/mic_fifo_adaptive_packetizer_defines.svh */
// ----------------------------------------------------------------------------
// mic fifo packetizer assertion macros
// shared assertion forms for the packetizer rtl
// ----------------------------------------------------------------------------
`ifndef MIC_FIFO_ADAPTIVE_PACKETIZER_DEFINES_SVH
`define MIC_FIFO_ADAPTIVE_PACKETIZER_DEFINES_SVH

// same-cycle implication under synchronous reset
`define MFAP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfap assertion failed");

// next-cycle implication under synchronous reset
`define MFAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfap assertion failed");

`endif

/* rtl/mfap_pkg.sv */
// ----------------------------------------------------------------------------
// mfap_pkg
// shared types, codes and constants of the mic fifo packetizer
// ----------------------------------------------------------------------------
package mfap_pkg;

  localparam int FIFO_FRAMES_DEFAULT = 2048;
  localparam int MAX_PACKET          = 64;
  localparam int QUEUE_DEPTH         = 2;
  localparam int CFG_DATA_W          = 12;
  localparam int CFG_INDEX_W         = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PKT_MIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PKT_NOM   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PKT_MAX   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_LOW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_HI  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MONO_MIX  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIC_ITF   = 3'd6;

  // register reset values
  localparam logic [6:0]  RST_PKT_MIN   = 7'd47;
  localparam logic [6:0]  RST_PKT_NOM   = 7'd48;
  localparam logic [6:0]  RST_PKT_MAX   = 7'd49;
  localparam logic [11:0] RST_DEPTH_LOW = 12'd288;
  localparam logic [11:0] RST_DEPTH_HI  = 12'd480;
  localparam logic [7:0]  RST_MIC_ITF   = 8'd2;

  typedef enum logic [1:0] {
    CMD_PUSH          = 2'd0,
    CMD_REQUEST       = 2'd1,
    CMD_SET_INTERFACE = 2'd2,
    CMD_UNUSED        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STORED         = 3'd0,
    ST_FULL_DROP      = 3'd1,
    ST_IDLE_IGNORE    = 3'd2,
    ST_PACKET_FRAME   = 3'd3,
    ST_UNDERFLOW      = 3'd4,
    ST_IDLE_NO_PACKET = 3'd5,
    ST_INTERFACE_DONE = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SIZE,
    BK_CAP,
    BK_CHECK,
    BK_READ
  } back_state_t;

  typedef struct packed {
    logic [6:0]  pkt_min;
    logic [6:0]  pkt_nom;
    logic [6:0]  pkt_max;
    logic [11:0] depth_low;
    logic [11:0] depth_high;
    logic        mono_mix;
    logic [7:0]  mic_itf;
  } cfg_t;

  typedef struct packed {
    cmd_t        op;
    logic [31:0] word;
    logic        itf_hit;
    logic        alt_on;
  } entry_t;

endpackage

/* rtl/mfap_front.sv */
// ----------------------------------------------------------------------------
// mfap_front
// command decode: classifies an accepted command and builds its queue entry
// ----------------------------------------------------------------------------
module mfap_front (
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] sample_left,
  input  logic signed [15:0] sample_right,
  input  logic [7:0]         interface_number,
  input  logic [7:0]         alt_setting,
  input  mfap_pkg::cfg_t     cfg,
  output logic               push,
  output mfap_pkg::entry_t   entry
);
  import mfap_pkg::*;

  cmd_t               op;
  logic signed [16:0] sum;
  logic signed [16:0] sum_adj;
  logic signed [16:0] mono;

  assign op = cmd_t'(cmd);

  // halve toward zero
  assign sum     = 17'(sample_left) + 17'(sample_right);
  assign sum_adj = sum + {16'd0, sum[16]};
  assign mono    = sum_adj >>> 1;

  always_comb begin
    entry.op      = op;
    entry.word    = cfg.mono_mix ? {16'd0, mono[15:0]} : {sample_right, sample_left};
    entry.itf_hit = (interface_number == cfg.mic_itf);
    entry.alt_on  = (alt_setting != 8'd0);
    case (op)
      CMD_PUSH, CMD_REQUEST, CMD_SET_INTERFACE: push = start && !busy;
      default:                                  push = 1'b0;
    endcase
  end

endmodule

/* rtl/mfap_queue.sv */
// ----------------------------------------------------------------------------
// mfap_queue
// short command queue between decode and execution
// ----------------------------------------------------------------------------
module mfap_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mfap_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             valid,
  output logic             full,
  output mfap_pkg::entry_t head
);
  import mfap_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign valid = (count != '0);
  assign full  = (count == CW'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/mfap_back.sv */
// ----------------------------------------------------------------------------
// mfap_back
// execution: frame memory, fifo pointers, packet sizing and frame readout
// ----------------------------------------------------------------------------
`include "mic_fifo_adaptive_packetizer_defines.svh"

module mfap_back #(
  parameter int FIFO_FRAMES = mfap_pkg::FIFO_FRAMES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mfap_pkg::cfg_t                       cfg,
  input  logic                                 q_valid,
  input  mfap_pkg::entry_t                     q_entry,
  output logic                                 q_pop,
  output logic                                 strobe,
  output logic [2:0]                           status,
  output logic signed [15:0]                   out_left,
  output logic signed [15:0]                   out_right,
  output logic                                 last,
  output logic [6:0]                           packet_frames,
  output logic [$clog2(FIFO_FRAMES + 1)-1:0]   fifo_depth
);
  import mfap_pkg::*;

  localparam int AW   = $clog2(FIFO_FRAMES);
  localparam int CW   = $clog2(FIFO_FRAMES + 1);
  localparam int CMPW = (CW > 12) ? CW : 12;

  logic [31:0]     mem [FIFO_FRAMES];
  logic [31:0]     rd_data;

  back_state_t     state, state_next;
  logic [AW-1:0]   rd_ptr, rd_ptr_next;
  logic [AW-1:0]   wr_ptr, wr_ptr_next;
  logic [CW-1:0]   frame_count, frame_count_next;
  logic            streaming_on, streaming_on_next;
  logic [6:0]      sel, sel_next;
  logic [6:0]      pkt_len, pkt_len_next;
  logic [6:0]      idx, idx_next;
  logic            strobe_next;
  status_t         status_q, status_next;
  logic            last_next;
  logic [6:0]      packet_frames_next;
  logic [CW-1:0]   fifo_depth_next;
  logic            frame_sel, frame_sel_next;
  logic            mem_we;
  logic            rd_en;

  logic [CMPW-1:0] depth_x;
  logic [6:0]      capped;
  logic [AW:0]     skip_sum;
  logic [AW-1:0]   skip_ptr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(FIFO_FRAMES - 1)) ? '0 : p + AW'(1);
  endfunction

  assign depth_x  = CMPW'(frame_count);
  assign capped   = (CMPW'(sel) > depth_x) ? 7'(frame_count) : sel;
  assign skip_sum = {1'b0, rd_ptr} + (AW + 1)'(pkt_len);
  assign skip_ptr = (skip_sum >= (AW + 1)'(FIFO_FRAMES)) ?
                    AW'(skip_sum - (AW + 1)'(FIFO_FRAMES)) : skip_sum[AW-1:0];

  // frame memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= q_entry.word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      frame_count   <= '0;
      streaming_on  <= 1'b0;
      strobe        <= 1'b0;
      frame_sel     <= 1'b0;
      status_q      <= ST_STORED;
      last          <= 1'b0;
      packet_frames <= '0;
      fifo_depth    <= '0;
      sel           <= '0;
      pkt_len       <= '0;
      idx           <= '0;
    end else begin
      state         <= state_next;
      rd_ptr        <= rd_ptr_next;
      wr_ptr        <= wr_ptr_next;
      frame_count   <= frame_count_next;
      streaming_on  <= streaming_on_next;
      strobe        <= strobe_next;
      frame_sel     <= frame_sel_next;
      status_q      <= status_next;
      last          <= last_next;
      packet_frames <= packet_frames_next;
      fifo_depth    <= fifo_depth_next;
      sel           <= sel_next;
      pkt_len       <= pkt_len_next;
      idx           <= idx_next;
    end
  end

  always_comb begin
    state_next         = state;
    rd_ptr_next        = rd_ptr;
    wr_ptr_next        = wr_ptr;
    frame_count_next   = frame_count;
    streaming_on_next  = streaming_on;
    sel_next           = sel;
    pkt_len_next       = pkt_len;
    idx_next           = idx;
    strobe_next        = 1'b0;
    frame_sel_next     = 1'b0;
    status_next        = status_q;
    last_next          = 1'b0;
    packet_frames_next = '0;
    fifo_depth_next    = fifo_depth;
    q_pop              = 1'b0;
    mem_we             = 1'b0;
    rd_en              = 1'b0;

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_entry.op)
            CMD_PUSH: begin
              strobe_next = 1'b1;
              last_next   = 1'b1;
              if (!streaming_on) begin
                status_next = ST_IDLE_IGNORE;
              end else if (frame_count == CW'(FIFO_FRAMES)) begin
                status_next = ST_FULL_DROP;
              end else begin
                mem_we           = 1'b1;
                wr_ptr_next      = ptr_inc(wr_ptr);
                frame_count_next = frame_count + CW'(1);
                status_next      = ST_STORED;
              end
              fifo_depth_next = frame_count_next;
            end
            CMD_REQUEST: begin
              if (!streaming_on) begin
                strobe_next     = 1'b1;
                last_next       = 1'b1;
                status_next     = ST_IDLE_NO_PACKET;
                fifo_depth_next = frame_count;
              end else if (depth_x < CMPW'(cfg.pkt_min)) begin
                strobe_next     = 1'b1;
                last_next       = 1'b1;
                status_next     = ST_UNDERFLOW;
                fifo_depth_next = frame_count;
              end else begin
                state_next = BK_SIZE;
              end
            end
            CMD_SET_INTERFACE: begin
              if (q_entry.itf_hit) begin
                streaming_on_next = q_entry.alt_on;
                rd_ptr_next       = '0;
                wr_ptr_next       = '0;
                frame_count_next  = '0;
              end
              strobe_next     = 1'b1;
              last_next       = 1'b1;
              status_next     = ST_INTERFACE_DONE;
              fifo_depth_next = frame_count_next;
            end
            default: begin
            end
          endcase
        end
      end
      BK_SIZE: begin
        if (depth_x > CMPW'(cfg.depth_high)) begin
          sel_next = cfg.pkt_max;
        end else if (depth_x < CMPW'(cfg.depth_low)) begin
          sel_next = cfg.pkt_min;
        end else begin
          sel_next = cfg.pkt_nom;
        end
        state_next = BK_CAP;
      end
      BK_CAP: begin
        pkt_len_next = (capped > 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : capped;
        state_next   = BK_CHECK;
      end
      BK_CHECK: begin
        if (pkt_len == '0) begin
          strobe_next     = 1'b1;
          last_next       = 1'b1;
          status_next     = ST_UNDERFLOW;
          fifo_depth_next = frame_count;
          state_next      = BK_IDLE;
        end else begin
          frame_count_next = frame_count - CW'(pkt_len);
          if (pkt_len < cfg.pkt_min) begin
            // too short after capping: drop the frames
            rd_ptr_next     = skip_ptr;
            strobe_next     = 1'b1;
            last_next       = 1'b1;
            status_next     = ST_UNDERFLOW;
            fifo_depth_next = frame_count_next;
            state_next      = BK_IDLE;
          end else begin
            idx_next   = '0;
            state_next = BK_READ;
          end
        end
      end
      BK_READ: begin
        rd_en              = 1'b1;
        rd_ptr_next        = ptr_inc(rd_ptr);
        strobe_next        = 1'b1;
        frame_sel_next     = 1'b1;
        status_next        = ST_PACKET_FRAME;
        packet_frames_next = pkt_len;
        fifo_depth_next    = frame_count;
        last_next          = (idx == pkt_len - 7'd1);
        idx_next           = idx + 7'd1;
        if (idx == pkt_len - 7'd1) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign status    = status_q;
  assign out_left  = frame_sel ? $signed(rd_data[15:0]) : 16'sd0;
  assign out_right = frame_sel ? $signed(rd_data[31:16]) : 16'sd0;

  `MFAP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, frame_count <= CW'(FIFO_FRAMES))
  `MFAP_ASSERT_NOW(a_off_empty, clk, rst, !streaming_on, frame_count == '0)
  `MFAP_ASSERT_NOW(a_pop_idle, clk, rst, q_pop, state == BK_IDLE)
  `MFAP_ASSERT_NEXT(a_read_emits, clk, rst, state == BK_READ, strobe && status_q == ST_PACKET_FRAME)

endmodule

/* rtl/mic_fifo_adaptive_packetizer.sv */
// ----------------------------------------------------------------------------
// mic_fifo_adaptive_packetizer
// stereo mic frame fifo with an adaptive isochronous packet source
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; commands wait in a
// two-entry queue, and busy is high only while that queue is full. Each
// result is shown for exactly one cycle with strobe high and cannot be held
// off by the receiver. A push, a set-interface or a packet request refused
// for streaming off or a shallow fifo is handled in BK_IDLE alone; its single
// result is registered and appears on the next cycle. Any other request
// passes BK_IDLE, BK_SIZE, BK_CAP and BK_CHECK to dispatch it, pick, cap and
// commit its length; a capped length of zero or below the minimum ends in
// underflow there, else BK_READ does one frame memory read a cycle, so
// frames stream out back to back. Frame memory contents are undefined after
// reset and need no clearing pass; only written frames are ever read.
// ----------------------------------------------------------------------------
module mic_fifo_adaptive_packetizer #(
  parameter int FIFO_FRAMES = mfap_pkg::FIFO_FRAMES_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [1:0]                                 cmd,
  input  logic signed [15:0]                         sample_left,
  input  logic signed [15:0]                         sample_right,
  input  logic [7:0]                                 interface_number,
  input  logic [7:0]                                 alt_setting,
  input  logic                                       cfg_write,
  input  logic [mfap_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [mfap_pkg::CFG_DATA_W-1:0]            cfg_data,
  output logic                                       strobe,
  output logic [2:0]                                 status,
  output logic signed [15:0]                         out_left,
  output logic signed [15:0]                         out_right,
  output logic                                       last,
  output logic [6:0]                                 packet_frames,
  output logic [$clog2(FIFO_FRAMES + 1)-1:0]         fifo_depth
);
  import mfap_pkg::*;

  cfg_t   cfg;
  logic   q_push;
  entry_t q_in;
  logic   q_pop;
  logic   q_valid;
  logic   q_full;
  entry_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pkt_min    <= RST_PKT_MIN;
      cfg.pkt_nom    <= RST_PKT_NOM;
      cfg.pkt_max    <= RST_PKT_MAX;
      cfg.depth_low  <= RST_DEPTH_LOW;
      cfg.depth_high <= RST_DEPTH_HI;
      cfg.mono_mix   <= 1'b0;
      cfg.mic_itf    <= RST_MIC_ITF;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PKT_MIN:   cfg.pkt_min    <= cfg_data[6:0];
        REG_PKT_NOM:   cfg.pkt_nom    <= cfg_data[6:0];
        REG_PKT_MAX:   cfg.pkt_max    <= cfg_data[6:0];
        REG_DEPTH_LOW: cfg.depth_low  <= cfg_data[11:0];
        REG_DEPTH_HI:  cfg.depth_high <= cfg_data[11:0];
        REG_MONO_MIX:  cfg.mono_mix   <= cfg_data[0];
        REG_MIC_ITF:   cfg.mic_itf    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = q_full;

  mfap_front u_front (
    .start            (start),
    .busy             (q_full),
    .cmd              (cmd),
    .sample_left      (sample_left),
    .sample_right     (sample_right),
    .interface_number (interface_number),
    .alt_setting      (alt_setting),
    .cfg              (cfg),
    .push             (q_push),
    .entry            (q_in)
  );

  mfap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .valid      (q_valid),
    .full       (q_full),
    .head       (q_head)
  );

  mfap_back #(
    .FIFO_FRAMES (FIFO_FRAMES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_entry       (q_head),
    .q_pop         (q_pop),
    .strobe        (strobe),
    .status        (status),
    .out_left      (out_left),
    .out_right     (out_right),
    .last          (last),
    .packet_frames (packet_frames),
    .fifo_depth    (fifo_depth)
  );

endmodule
